### sv/atci_pkg.sv
`timescale 1ns / 1ps

package atci_pkg;

    typedef struct packed {
        logic [31:0] block_address;
        logic [7:0]  sector_count;
        logic        is_write;
        logic        is_slave;
        logic        lba_capable;
    } t_in_word;

    typedef struct packed {
        logic [3:0] reg_index;
        logic [7:0] reg_value;
        logic       last;
        logic       rejected;
    } t_out_word;

    typedef struct packed {
        logic       rejected;
        logic       lba48;
        logic [7:0] devsel;
        logic [7:0] count0;
        logic [7:0] lba0;
        logic [7:0] lba1;
        logic [7:0] lba2;
        logic [7:0] lba3;
        logic [7:0] command;
    } t_desc;

    localparam logic [3:0] REG_NONE    = 4'd0;
    localparam logic [3:0] REG_COUNT0  = 4'd2;
    localparam logic [3:0] REG_LBA0    = 4'd3;
    localparam logic [3:0] REG_LBA1    = 4'd4;
    localparam logic [3:0] REG_LBA2    = 4'd5;
    localparam logic [3:0] REG_DEVSEL  = 4'd6;
    localparam logic [3:0] REG_COMMAND = 4'd7;
    localparam logic [3:0] REG_COUNT1  = 4'd8;
    localparam logic [3:0] REG_LBA3    = 4'd9;
    localparam logic [3:0] REG_LBA4    = 4'd10;
    localparam logic [3:0] REG_LBA5    = 4'd11;
    localparam logic [3:0] REG_CONTROL = 4'd12;

    localparam logic [7:0] CFG_DRIVE_PRESENT = 8'd0;
    localparam logic [7:0] CFG_CAPACITY      = 8'd1;
    localparam logic [7:0] CFG_CONTROL_BASE  = 8'd2;

    localparam logic [7:0] CMD_READ_PIO      = 8'h20;
    localparam logic [7:0] CMD_WRITE_PIO     = 8'h30;
    localparam logic [7:0] CMD_READ_PIO_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE_PIO_EXT = 8'h34;

    localparam logic [7:0] DEVSEL_LBA = 8'hE0;
    localparam logic [7:0] DEVSEL_CHS = 8'hA0;
    localparam logic [7:0] CTRL_HOB   = 8'h80;

    // Reciprocal of 63 scaled by 2^34, exact for dividends below 2^28.
    localparam logic [28:0] RECIP_63       = 29'd272696337;
    localparam int          RECIP_63_SHIFT = 34;

    localparam logic [4:0] LAST_STEP_LBA48 = 5'd17;
    localparam logic [4:0] LAST_STEP_SHORT = 5'd5;
    localparam logic [4:0] SHORT_STEP_BIAS = 5'd12;

endpackage

### sv/ata_taskfile_command_issuer.sv
`timescale 1ns / 1ps
// The first word of a request appears after it has passed the three front stages and been
// loaded into the output sequencer. A request yields 18 words in LBA48 mode, 6 in LBA28 or
// CHS mode, 1 if rejected; the front stages take a request every cycle unless stalled.
// Reset is synchronous and active low; it empties the pipeline and restores the
// configuration registers to drive absent, zero capacity and a control byte of 1.

module ata_taskfile_command_issuer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  atci_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output atci_pkg::t_out_word o_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import atci_pkg::*;

    logic        r_present;
    logic [31:0] r_capacity;
    logic [7:0]  r_control_base;

    logic        desc_valid;
    logic        desc_ready;
    t_desc       desc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present      <= 1'b0;
            r_capacity     <= 32'd0;
            r_control_base <= 8'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DRIVE_PRESENT: r_present      <= i_cfg_data[0];
                CFG_CAPACITY:      r_capacity     <= i_cfg_data;
                CFG_CONTROL_BASE:  r_control_base <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    atci_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_word     (i_word),
        .i_present  (r_present),
        .i_capacity (r_capacity),
        .o_valid    (desc_valid),
        .i_ready    (desc_ready),
        .o_desc     (desc)
    );

    atci_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (desc_valid),
        .o_ready        (desc_ready),
        .i_desc         (desc),
        .i_control_base (r_control_base),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_word         (o_word)
    );

endmodule

### sv/atci_front.sv
`timescale 1ns / 1ps

module atci_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  atci_pkg::t_in_word i_word,
    input  logic               i_present,
    input  logic [31:0]        i_capacity,
    output logic               o_valid,
    input  logic               i_ready,
    output atci_pkg::t_desc    o_desc
);
    import atci_pkg::*;

    logic        r_s1_v;
    t_in_word    r_s1_in;
    logic        r_s1_rej;
    logic [56:0] r_s1_prod;

    logic        r_s2_v;
    t_in_word    r_s2_in;
    logic        r_s2_rej;
    logic [21:0] r_s2_q;
    logic [7:0]  r_s2_sect;

    logic        r_s3_v;
    t_desc       r_s3_desc;

    logic        rdy1, rdy2, rdy3;
    logic [32:0] sum_end;
    logic [21:0] q;
    logic [27:0] q63;
    logic [27:0] rem;
    t_desc       n_desc;

    assign rdy3    = !r_s3_v || i_ready;
    assign rdy2    = !r_s2_v || rdy3;
    assign rdy1    = !r_s1_v || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_s3_v;
    assign o_desc  = r_s3_desc;

    assign sum_end = {1'b0, i_word.block_address} + {25'd0, i_word.sector_count};

    assign q   = r_s1_prod[RECIP_63_SHIFT +: 22];
    assign q63 = {q, 6'd0} - {6'd0, q};
    assign rem = r_s1_in.block_address[27:0] - q63;

    always_comb begin
        n_desc          = '0;
        n_desc.rejected = r_s2_rej;
        n_desc.lba48    = (r_s2_in.block_address[31:28] != 4'd0);
        n_desc.count0   = r_s2_in.sector_count;
        n_desc.lba3     = r_s2_in.block_address[31:24];
        if (n_desc.lba48) begin
            n_desc.devsel  = DEVSEL_LBA | {3'd0, r_s2_in.is_slave, 4'd0};
            n_desc.lba0    = r_s2_in.block_address[7:0];
            n_desc.lba1    = r_s2_in.block_address[15:8];
            n_desc.lba2    = r_s2_in.block_address[23:16];
            n_desc.command = r_s2_in.is_write ? CMD_WRITE_PIO_EXT : CMD_READ_PIO_EXT;
        end else if (r_s2_in.lba_capable) begin
            n_desc.devsel  = DEVSEL_LBA | {3'd0, r_s2_in.is_slave, r_s2_in.block_address[27:24]};
            n_desc.lba0    = r_s2_in.block_address[7:0];
            n_desc.lba1    = r_s2_in.block_address[15:8];
            n_desc.lba2    = r_s2_in.block_address[23:16];
            n_desc.command = r_s2_in.is_write ? CMD_WRITE_PIO : CMD_READ_PIO;
        end else begin
            n_desc.devsel  = DEVSEL_CHS | {3'd0, r_s2_in.is_slave, r_s2_q[3:0]};
            n_desc.lba0    = r_s2_sect;
            n_desc.lba1    = r_s2_q[11:4];
            n_desc.lba2    = r_s2_q[19:12];
            n_desc.command = r_s2_in.is_write ? CMD_WRITE_PIO : CMD_READ_PIO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_v <= i_valid;
            end
            if (rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (rdy3) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_s1_in   <= i_word;
            r_s1_rej  <= !i_present || (sum_end > {1'b0, i_capacity});
            r_s1_prod <= i_word.block_address[27:0] * RECIP_63;
        end
        if (rdy2 && r_s1_v) begin
            r_s2_in   <= r_s1_in;
            r_s2_rej  <= r_s1_rej;
            r_s2_q    <= q;
            r_s2_sect <= {2'd0, rem[5:0]} + 8'd1;
        end
        if (rdy3 && r_s2_v) begin
            r_s3_desc <= n_desc;
        end
    end

endmodule

### sv/atci_emit.sv
`timescale 1ns / 1ps

module atci_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  atci_pkg::t_desc     i_desc,
    input  logic [7:0]          i_control_base,
    output logic                o_valid,
    input  logic                i_ready,
    output atci_pkg::t_out_word o_word
);
    import atci_pkg::*;

    logic       r_busy;
    logic [4:0] r_step;
    t_desc      r_desc;

    logic [4:0] last_step;
    logic [4:0] seq;
    logic       at_last;
    logic [7:0] ctrl_hob;

    assign last_step = r_desc.rejected ? 5'd0 :
                       (r_desc.lba48 ? LAST_STEP_LBA48 : LAST_STEP_SHORT);
    assign at_last   = (r_step == last_step);
    assign seq       = (r_desc.lba48 || r_step == 5'd0) ? r_step : r_step + SHORT_STEP_BIAS;
    assign ctrl_hob  = CTRL_HOB | i_control_base;

    assign o_valid = r_busy;
    assign o_ready = !r_busy || (i_ready && at_last);

    always_comb begin
        o_word = '0;
        if (r_desc.rejected) begin
            o_word.reg_index = REG_NONE;
            o_word.reg_value = 8'd0;
            o_word.rejected  = 1'b1;
        end else begin
            case (seq)
                5'd0:  begin o_word.reg_index = REG_DEVSEL;  o_word.reg_value = r_desc.devsel; end
                5'd1:  begin o_word.reg_index = REG_CONTROL; o_word.reg_value = ctrl_hob; end
                5'd2:  begin o_word.reg_index = REG_COUNT1;  o_word.reg_value = 8'd0; end
                5'd3:  begin o_word.reg_index = REG_CONTROL; o_word.reg_value = i_control_base; end
                5'd4:  begin o_word.reg_index = REG_CONTROL; o_word.reg_value = ctrl_hob; end
                5'd5:  begin o_word.reg_index = REG_LBA3;    o_word.reg_value = r_desc.lba3; end
                5'd6:  begin o_word.reg_index = REG_CONTROL; o_word.reg_value = i_control_base; end
                5'd7:  begin o_word.reg_index = REG_CONTROL; o_word.reg_value = ctrl_hob; end
                5'd8:  begin o_word.reg_index = REG_LBA4;    o_word.reg_value = 8'd0; end
                5'd9:  begin o_word.reg_index = REG_CONTROL; o_word.reg_value = i_control_base; end
                5'd10: begin o_word.reg_index = REG_CONTROL; o_word.reg_value = ctrl_hob; end
                5'd11: begin o_word.reg_index = REG_LBA5;    o_word.reg_value = 8'd0; end
                5'd12: begin o_word.reg_index = REG_CONTROL; o_word.reg_value = i_control_base; end
                5'd13: begin o_word.reg_index = REG_COUNT0;  o_word.reg_value = r_desc.count0; end
                5'd14: begin o_word.reg_index = REG_LBA0;    o_word.reg_value = r_desc.lba0; end
                5'd15: begin o_word.reg_index = REG_LBA1;    o_word.reg_value = r_desc.lba1; end
                5'd16: begin o_word.reg_index = REG_LBA2;    o_word.reg_value = r_desc.lba2; end
                default: begin
                    o_word.reg_index = REG_COMMAND;
                    o_word.reg_value = r_desc.command;
                end
            endcase
        end
        o_word.last = at_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 5'd0;
        end else if (o_ready) begin
            r_busy <= i_valid;
            r_step <= 5'd0;
        end else if (i_ready) begin
            r_step <= r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_desc <= i_desc;
        end
    end

endmodule
